// ----- design/mjd_to_gregorian_date_time_core_assert.svh -----
// ----------------------------------------------------------------------------
// MJD core assertion macros
// Clocked property checks for the MJD to Gregorian date/time core.
// ----------------------------------------------------------------------------
`ifndef MJD_TO_GREGORIAN_DATE_TIME_CORE_ASSERT_SVH
`define MJD_TO_GREGORIAN_DATE_TIME_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge outside reset
`define MJD_ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("mjd core: invariant violated");

// consequent holds in the cycle the antecedent is seen
`define MJD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mjd core: implication violated");

`else

`define MJD_ASSERT_HOLDS(lbl, clk, rst, expr)

`define MJD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- design/mjd_pkg.sv -----
// ----------------------------------------------------------------------------
// MJD conversion package
// Field widths, calendar constants and shared helpers for the MJD core.
// ----------------------------------------------------------------------------
package mjd_pkg;

   // port field widths
   localparam int MJD_DAY_W  = 23;
   localparam int FRAC_W     = 32;
   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DOM_W      = 5;
   localparam int HOUR_W     = 5;
   localparam int MINUTE_W   = 6;
   localparam int SECOND_W   = 6;

   // latency of one constant divider
   localparam int CDIV_LAT   = 3;

   // valid day range: 0001-01-01 .. 9999-12-31
   localparam logic signed [MJD_DAY_W-1:0] MJD_LOW  = -23'sd678575;
   localparam logic signed [MJD_DAY_W-1:0] MJD_HIGH = 23'sd2973483;

   // 2400001 (MJD to JDN) plus 32044 (epoch shift of the integer inverse)
   localparam logic [MJD_DAY_W-1:0] A_OFFSET = 23'd2432045;

   // calendar cycles
   localparam int ERA_DAYS   = 146097;
   localparam int QUAD_DAYS  = 1461;
   localparam int MONTH_SPAN = 153;
   localparam int SEC_HOUR   = 3600;
   localparam int SEC_MINUTE = 60;

   // 86400 = 675 * 2^7
   localparam int SEC_SCALE  = 675;
   localparam int SEC_POW2   = 7;
   localparam int SECS_W     = 17;
   localparam int SCALE_W    = 10;

   // year arithmetic
   localparam int YEAR_ACC_W = 15;
   localparam logic [YEAR_ACC_W-1:0] YEAR_BIAS = 15'd4800;
   localparam logic [MONTH_W-1:0] MONTH_WRAP = 4'd10;

   // divider widths
   localparam int ERA_IN_W   = 25;
   localparam int ERA_Q_W    = 8;
   localparam int ERA_R_W    = 18;
   localparam int QUAD_IN_W  = 18;
   localparam int QUAD_Q_W   = 8;
   localparam int QUAD_R_W   = 11;
   localparam int MON_IN_W   = 11;
   localparam int MON_Q_W    = 4;
   localparam int MON_R_W    = 8;
   localparam int HOUR_IN_W  = 17;
   localparam int HOUR_Q_W   = 6;
   localparam int HOUR_R_W   = 12;
   localparam int MIN_IN_W   = 12;
   localparam int MIN_Q_W    = 7;
   localparam int MIN_R_W    = 6;

   // fields carried alongside the month divider
   typedef struct packed {
      logic                  oor;
      logic [ERA_Q_W-1:0]    era;
      logic [QUAD_Q_W-1:0]   quad;
      logic [HOUR_W-1:0]     hour;
      logic [MINUTE_W-1:0]   minute;
      logic [SECOND_W-1:0]   second;
   } date_side_type;

   // floor(x / 5) for 8-bit x (x < 256), by reciprocal 205 / 1024
   function automatic logic [DOM_W-1:0] div5(input logic [MON_R_W-1:0] x);
      logic [15:0] prod;
      prod = 16'(x) * 16'd205;
      return DOM_W'(prod >> 10);
   endfunction

endpackage

// ----- design/mjd_delay.sv -----
// ----------------------------------------------------------------------------
// MJD delay line
// Fixed-depth register line that keeps side fields aligned with a divider.
// ----------------------------------------------------------------------------
module mjd_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 3
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign out_data = tap_ff[DEPTH-1];

endmodule

// ----- design/mjd_cdiv.sv -----
// ----------------------------------------------------------------------------
// MJD constant divider
// Three-stage pipelined divide by a constant: reciprocal estimate,
// back-multiply, one compare-and-subtract correction.
// ----------------------------------------------------------------------------
`include "mjd_to_gregorian_date_time_core_assert.svh"

module mjd_cdiv #(
   parameter int DIVISOR = 3,
   parameter int IN_W    = 8,
   parameter int Q_W     = 7,
   parameter int R_W     = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [IN_W-1:0] in_dividend,
   output logic            out_valid,
   output logic [Q_W-1:0]  out_quotient,
   output logic [R_W-1:0]  out_remainder
);

   import mjd_pkg::*;

   localparam int PW = 2 * IN_W + 1;
   localparam int BW = IN_W + Q_W;
   // floor(2^IN_W / DIVISOR): estimate is never high and at most one low
   localparam logic [IN_W:0] RECIP = (IN_W + 1)'((64'd1 << IN_W) / DIVISOR);
   localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

   logic            va_ff, vb_ff, vc_ff;
   logic [IN_W-1:0] xa_ff, xb_ff;
   logic [Q_W-1:0]  qa_ff, qb_ff, qc_ff;
   logic [IN_W-1:0] pb_ff;
   logic [R_W-1:0]  rc_ff;

   logic [PW-1:0]   est_prod;
   logic [Q_W-1:0]  qa_in;
   logic [BW-1:0]   back_prod;
   logic [IN_W-1:0] r_raw;
   logic [Q_W-1:0]  qc_in;
   logic [R_W-1:0]  rc_in;
   logic [BW-1:0]   chk_sum;

   // stage a: quotient estimate
   assign est_prod = PW'(in_dividend) * PW'(RECIP);
   assign qa_in    = Q_W'(est_prod >> IN_W);

   // stage b: multiply the estimate back
   assign back_prod = BW'(qa_ff) * BW'(DIVISOR);

   // stage c: fix an estimate that came out one low
   always_comb begin
      r_raw = xb_ff - pb_ff;
      if (r_raw >= DIV_C) begin
         qc_in = qb_ff + Q_W'(1);
         rc_in = R_W'(r_raw - DIV_C);
      end else begin
         qc_in = qb_ff;
         rc_in = R_W'(r_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff <= in_dividend;
      qa_ff <= qa_in;
      xb_ff <= xa_ff;
      qb_ff <= qa_ff;
      pb_ff <= back_prod[IN_W-1:0];
      qc_ff <= qc_in;
      rc_ff <= rc_in;
   end

   assign out_valid     = vc_ff;
   assign out_quotient  = qc_ff;
   assign out_remainder = rc_ff;

   assign chk_sum = BW'(qc_ff) * BW'(DIVISOR) + BW'(rc_ff);

   `MJD_ASSERT_IMPLIES(a_rem_below_divisor, clock, reset, vc_ff, BW'(rc_ff) < BW'(DIVISOR))
   `MJD_ASSERT_IMPLIES(a_est_one_low, clock, reset, vb_ff, BW'(r_raw) < BW'(2 * DIVISOR))
   `MJD_ASSERT_IMPLIES(a_quot_rebuilds, clock, reset, vc_ff, chk_sum == BW'($past(xb_ff)))

endmodule

// ----- design/mjd_to_gregorian_date_time_core.sv -----
// ----------------------------------------------------------------------------
// MJD to Gregorian date/time core
// Converts a modified Julian day plus day fraction into year, month, day,
// hour, minute and whole second, flagging days outside years 1..9999.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 word
//   --------  ------------------------  -----------------------------------
//   request   start, busy               req_mjd_day, req_day_fraction
//   response  rsp_strobe (one cycle)    rsp_year .. rsp_out_of_range
//
// One word enters per cycle; each word's response strobes after the input
// stage, three chained constant dividers and the output stage.
// Throughput is set by nothing but the clock: every stage is a register.
// The response side cannot stall, so the pipeline never holds; busy is
// high only while reset is asserted.
// Synchronous reset clears the valid bits; data registers are left alone.
// ----------------------------------------------------------------------------
`include "mjd_to_gregorian_date_time_core_assert.svh"

module mjd_to_gregorian_date_time_core #(
   parameter int FRACTION_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [mjd_pkg::MJD_DAY_W-1:0]  req_mjd_day,
   input  logic [mjd_pkg::FRAC_W-1:0]            req_day_fraction,
   output logic                                  rsp_strobe,
   output logic [mjd_pkg::YEAR_W-1:0]            rsp_year,
   output logic [mjd_pkg::MONTH_W-1:0]           rsp_month,
   output logic [mjd_pkg::DOM_W-1:0]             rsp_day_of_month,
   output logic [mjd_pkg::HOUR_W-1:0]            rsp_hour_of_day,
   output logic [mjd_pkg::MINUTE_W-1:0]          rsp_minute_of_hour,
   output logic [mjd_pkg::SECOND_W-1:0]          rsp_second_of_minute,
   output logic                                  rsp_out_of_range
);

   import mjd_pkg::*;

   localparam int PROD_W = FRAC_W + SCALE_W;
   // seconds = floor(675 * fraction / 2^(FRACTION_BITS - 7))
   localparam int SHIFT = FRACTION_BITS - SEC_POW2;
   localparam logic [FRAC_W-1:0] FRAC_MASK = (FRACTION_BITS >= FRAC_W) ?
      {FRAC_W{1'b1}} : FRAC_W'((64'd1 << FRACTION_BITS) - 64'd1);

   // ---------------------------------------------------------------------
   // Input stage: day offset, range check, fraction scaled to seconds
   // ---------------------------------------------------------------------
   logic                  accept;
   logic [MJD_DAY_W-1:0]  a_in;
   logic [ERA_IN_W-1:0]   x1_in;
   logic                  oor_in;
   logic [FRAC_W-1:0]     frac_in;
   logic [PROD_W-1:0]     sec_prod;
   logic [SECS_W-1:0]     secs_in;

   logic                  s1_valid_ff;
   logic [ERA_IN_W-1:0]   s1_x1_ff;
   logic                  s1_oor_ff;
   logic [SECS_W-1:0]     s1_secs_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      oor_in   = (req_mjd_day < MJD_LOW) || (req_mjd_day > MJD_HIGH);
      // a = JDN + 32044; only meaningful in range, wraps harmlessly otherwise
      a_in     = req_mjd_day + A_OFFSET;
      x1_in    = {a_in, 2'b11};
      frac_in  = req_day_fraction & FRAC_MASK;
      sec_prod = PROD_W'(frac_in) * PROD_W'(SEC_SCALE);
      secs_in  = SECS_W'(sec_prod >> SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_x1_ff   <= x1_in;
      s1_oor_ff  <= oor_in;
      s1_secs_ff <= secs_in;
   end

   // ---------------------------------------------------------------------
   // First divider pair: 400-year eras, and hours of the day
   // ---------------------------------------------------------------------
   logic                  era_valid;
   logic [ERA_Q_W-1:0]    era_q;
   logic [ERA_R_W-1:0]    era_r;
   logic                  hour_valid;
   logic [HOUR_Q_W-1:0]   hour_q;
   logic [HOUR_R_W-1:0]   hour_r;
   logic                  oor_d1;

   mjd_cdiv #(
      .DIVISOR (ERA_DAYS),
      .IN_W    (ERA_IN_W),
      .Q_W     (ERA_Q_W),
      .R_W     (ERA_R_W)
   ) u_div_era (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid_ff),
      .in_dividend   (s1_x1_ff),
      .out_valid     (era_valid),
      .out_quotient  (era_q),
      .out_remainder (era_r)
   );

   mjd_cdiv #(
      .DIVISOR (SEC_HOUR),
      .IN_W    (HOUR_IN_W),
      .Q_W     (HOUR_Q_W),
      .R_W     (HOUR_R_W)
   ) u_div_hour (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid_ff),
      .in_dividend   (s1_secs_ff),
      .out_valid     (hour_valid),
      .out_quotient  (hour_q),
      .out_remainder (hour_r)
   );

   mjd_delay #(
      .WIDTH (1),
      .DEPTH (CDIV_LAT)
   ) u_dly_oor (
      .clock    (clock),
      .in_data  (s1_oor_ff),
      .out_data (oor_d1)
   );

   // ---------------------------------------------------------------------
   // Second divider pair: 4-year cycles, and minutes of the hour
   // 4c + 3 is the era remainder with its low two bits forced high
   // ---------------------------------------------------------------------
   localparam int SIDE2_W = 1 + ERA_Q_W + HOUR_W;

   logic [QUAD_IN_W-1:0]  y2;
   logic                  quad_valid;
   logic [QUAD_Q_W-1:0]   quad_q;
   logic [QUAD_R_W-1:0]   quad_r;
   logic                  min_valid;
   logic [MIN_Q_W-1:0]    min_q;
   logic [MIN_R_W-1:0]    min_r;
   logic [SIDE2_W-1:0]    side2_d;

   assign y2 = {era_r[ERA_R_W-1:2], 2'b11};

   mjd_cdiv #(
      .DIVISOR (QUAD_DAYS),
      .IN_W    (QUAD_IN_W),
      .Q_W     (QUAD_Q_W),
      .R_W     (QUAD_R_W)
   ) u_div_quad (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (era_valid),
      .in_dividend   (y2),
      .out_valid     (quad_valid),
      .out_quotient  (quad_q),
      .out_remainder (quad_r)
   );

   mjd_cdiv #(
      .DIVISOR (SEC_MINUTE),
      .IN_W    (MIN_IN_W),
      .Q_W     (MIN_Q_W),
      .R_W     (MIN_R_W)
   ) u_div_min (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (hour_valid),
      .in_dividend   (hour_r),
      .out_valid     (min_valid),
      .out_quotient  (min_q),
      .out_remainder (min_r)
   );

   mjd_delay #(
      .WIDTH (SIDE2_W),
      .DEPTH (CDIV_LAT)
   ) u_dly_era (
      .clock    (clock),
      .in_data  ({oor_d1, era_q, hour_q[HOUR_W-1:0]}),
      .out_data (side2_d)
   );

   // ---------------------------------------------------------------------
   // Month divider: m = (5e + 2) / 153, e = day within the shifted year
   // Carry everything else alongside it
   // ---------------------------------------------------------------------
   logic [QUAD_R_W-3:0]   doy;
   logic [MON_IN_W-1:0]   x3;
   logic                  mon_valid;
   logic [MON_Q_W-1:0]    mon_q;
   logic [MON_R_W-1:0]    mon_r;
   date_side_type         side3_in;
   date_side_type         side3;

   assign doy = quad_r[QUAD_R_W-1:2];
   assign x3  = MON_IN_W'(doy) * MON_IN_W'(5) + MON_IN_W'(2);

   always_comb begin
      side3_in.oor    = side2_d[SIDE2_W-1];
      side3_in.era    = side2_d[HOUR_W +: ERA_Q_W];
      side3_in.hour   = side2_d[HOUR_W-1:0];
      side3_in.quad   = quad_q;
      side3_in.minute = min_q[MINUTE_W-1:0];
      side3_in.second = min_r;
   end

   mjd_cdiv #(
      .DIVISOR (MONTH_SPAN),
      .IN_W    (MON_IN_W),
      .Q_W     (MON_Q_W),
      .R_W     (MON_R_W)
   ) u_div_month (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (quad_valid),
      .in_dividend   (x3),
      .out_valid     (mon_valid),
      .out_quotient  (mon_q),
      .out_remainder (mon_r)
   );

   mjd_delay #(
      .WIDTH ($bits(date_side_type)),
      .DEPTH (CDIV_LAT)
   ) u_dly_side (
      .clock    (clock),
      .in_data  (side3_in),
      .out_data (side3)
   );

   // ---------------------------------------------------------------------
   // Output stage: assemble the date, zero it when out of range
   // The month remainder 5e + 2 - 153m gives the day as floor(r / 5) + 1
   // ---------------------------------------------------------------------
   logic                  wrap;
   logic [MONTH_W-1:0]    month_calc;
   logic [DOM_W-1:0]      dom_calc;
   logic [YEAR_ACC_W-1:0] year_acc;

   logic                  rsp_valid_ff;
   logic [YEAR_W-1:0]     rsp_year_ff;
   logic [MONTH_W-1:0]    rsp_month_ff;
   logic [DOM_W-1:0]      rsp_dom_ff;
   logic [HOUR_W-1:0]     rsp_hour_ff;
   logic [MINUTE_W-1:0]   rsp_minute_ff;
   logic [SECOND_W-1:0]   rsp_second_ff;
   logic                  rsp_oor_ff;

   logic [YEAR_W-1:0]     rsp_year_in;
   logic [MONTH_W-1:0]    rsp_month_in;
   logic [DOM_W-1:0]      rsp_dom_in;

   always_comb begin
      wrap       = (mon_q >= MONTH_WRAP);
      month_calc = wrap ? (mon_q - MONTH_W'(9)) : (mon_q + MONTH_W'(3));
      dom_calc   = div5(mon_r) + DOM_W'(1);
      year_acc   = YEAR_ACC_W'(side3.era) * YEAR_ACC_W'(100)
                 + YEAR_ACC_W'(side3.quad) + YEAR_ACC_W'(wrap) - YEAR_BIAS;
      if (side3.oor) begin
         rsp_year_in  = '0;
         rsp_month_in = '0;
         rsp_dom_in   = '0;
      end else begin
         rsp_year_in  = year_acc[YEAR_W-1:0];
         rsp_month_in = month_calc;
         rsp_dom_in   = dom_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mon_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_dom_ff    <= rsp_dom_in;
      rsp_hour_ff   <= side3.hour;
      rsp_minute_ff <= side3.minute;
      rsp_second_ff <= side3.second;
      rsp_oor_ff    <= side3.oor;
   end

   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_year             = rsp_year_ff;
   assign rsp_month            = rsp_month_ff;
   assign rsp_day_of_month     = rsp_dom_ff;
   assign rsp_hour_of_day      = rsp_hour_ff;
   assign rsp_minute_of_hour   = rsp_minute_ff;
   assign rsp_second_of_minute = rsp_second_ff;
   assign rsp_out_of_range     = rsp_oor_ff;

   // date and time lanes must advance in lockstep
   `MJD_ASSERT_HOLDS(a_lanes_aligned, clock, reset, (era_valid == hour_valid) && (quad_valid == min_valid))
   `MJD_ASSERT_IMPLIES(a_oor_zeroes_date, clock, reset, rsp_valid_ff && rsp_oor_ff, (rsp_year_ff == '0) && (rsp_month_ff == '0) && (rsp_dom_ff == '0))
   `MJD_ASSERT_IMPLIES(a_date_legal, clock, reset, rsp_valid_ff && !rsp_oor_ff, (rsp_month_ff >= MONTH_W'(1)) && (rsp_month_ff <= MONTH_W'(12)) && (rsp_dom_ff != '0))
   `MJD_ASSERT_IMPLIES(a_time_legal, clock, reset, rsp_valid_ff, (rsp_hour_ff <= HOUR_W'(23)) && (rsp_minute_ff <= MINUTE_W'(59)) && (rsp_second_ff <= SECOND_W'(59)))

endmodule
